// ===== hw/rtl/w2s_pkg.sv =====
// Shared constants, types and helper functions for the world-to-screen projection block.
package w2s_pkg;

  localparam int FRAC_BITS = 16;

  // Multiplier operand A: wide enough that a clamped ndc value still saturates the screen map.
  localparam int MA_W  = (FRAC_BITS + 15 > 33) ? FRAC_BITS + 15 : 33;
  localparam int PW    = MA_W + 32;
  localparam int ACC_W = PW + 2;

  // Divider: |row| << FRAC_BITS over a positive 31-bit w.
  localparam int DIV_W  = 32 + FRAC_BITS;
  localparam int QW     = DIV_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam int CFG_W  = 14;
  localparam int HALF_W = CFG_W - 1;

  localparam logic [CFG_W-1:0] SW_RESET = 14'd1920;
  localparam logic [CFG_W-1:0] SH_RESET = 14'd1080;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PROJ = 1'b1;

  // 0.1 rounded up in fixed point
  localparam logic signed [31:0] W_MIN = 32'(((1 << FRAC_BITS) + 9) / 10);

  localparam logic signed [MA_W-1:0] MAC_ONE = {{(MA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ACC_S32_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_S32_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  localparam logic signed [QW-1:0] Q_CL_MAX = {{(QW-MA_W+1){1'b0}}, {(MA_W-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_CL_MIN = {{(QW-MA_W+1){1'b1}}, {(MA_W-1){1'b0}}};

  typedef struct packed {
    logic issue;
    logic init;   // first term of a sum: start from the init value
    logic shift;  // scale product down by FRAC_BITS (floor)
    logic last;   // last term of a sum: flag the result
  } mac_ctl_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIV_W-1:0] dividend;
    logic [30:0]      divisor;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_S32_MAX) r = 32'sh7fff_ffff;
    else if (v < ACC_S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [MA_W-1:0] clamp_ndc(input logic signed [QW-1:0] q);
    logic signed [MA_W-1:0] r;
    if (q > Q_CL_MAX) r = Q_CL_MAX[MA_W-1:0];
    else if (q < Q_CL_MIN) r = Q_CL_MIN[MA_W-1:0];
    else r = q[MA_W-1:0];
    return r;
  endfunction

  function automatic logic signed [MA_W-1:0] sext_a(input logic signed [31:0] v);
    return {{(MA_W-32){v[31]}}, v};
  endfunction

endpackage

// ===== hw/rtl/w2s_mac.sv =====
// Shared multiply-accumulate unit: registered product, then shift and accumulate.
module w2s_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  w2s_pkg::mac_ctl_t              ctl,
  input  logic signed [w2s_pkg::MA_W-1:0]  a,
  input  logic signed [31:0]             b,
  input  logic signed [w2s_pkg::ACC_W-1:0] init_val,
  output logic signed [w2s_pkg::ACC_W-1:0] acc,
  output logic                           res_valid
);
  import w2s_pkg::*;

  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] init_r;
  mac_ctl_t                ctl_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod   <= a * b;
      init_r <= init_val;
    end
  end

  assign prod_ext = {{(ACC_W-PW){prod[PW-1]}}, prod};
  assign term     = ctl_r.shift ? (prod_ext >>> FRAC_BITS) : prod_ext;
  assign base     = ctl_r.init ? init_r : acc;

  always_ff @(posedge clk) begin
    if (ctl_r.issue) begin
      acc <= base + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= ctl_r.issue & ctl_r.last;
    end
  end

endmodule

// ===== hw/rtl/w2s_div.sv =====
// Restoring divider, one quotient bit per cycle, signed result from magnitude and sign.
module w2s_div (
  input  logic                          clk,
  input  logic                          rst,
  input  w2s_pkg::div_req_t             req,
  output logic                          done,
  output logic signed [w2s_pkg::QW-1:0] quotient
);
  import w2s_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  dq;
  logic [30:0]       rem;
  logic [30:0]       dvs;
  logic              neg;
  logic [31:0]       rem_sh;
  logic              ge;
  logic [31:0]       diff;
  logic [QW-1:0]     mag;

  assign rem_sh = {rem, dq[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      cnt <= DCNT_W'(DIV_W - 1);
      dq  <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
      neg <= req.neg;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      dq  <= {dq[DIV_W-2:0], ge};
      rem <= ge ? diff[30:0] : rem_sh[30:0];
    end
  end

  assign mag      = {1'b0, dq};
  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule

// ===== hw/rtl/world_to_screen_projection.sv =====
// Perspective projection top level: matrix store, sequencer, shared MAC and divider.
//
// Each transaction either loads one coefficient of the 4x4 row-major view matrix
// (cmd 0, no result) or projects a point (cmd 1, one result). A point is worked
// on one at a time: nine products and three constant terms go through the shared
// multiply-accumulate unit, then x and y are divided by w one after the other in
// a restoring divider that retires one quotient bit per cycle, then two more MAC
// passes map the result to the viewport. A point with w below 0.1 is not divided
// and returns with zero coordinates. The divider sets the pace. The result sits
// in an output register, so the next transaction is taken while it waits; a second
// result waits in the done state until the first is read.
// screen_width and screen_height may be written through cfg_* only while idle.
module world_to_screen_projection (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [w2s_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [3:0]                coef_index,
  input  logic signed [31:0]        coef_value,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        pos_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      visible,
  output logic signed [31:0]        screen_x,
  output logic signed [31:0]        screen_y
);
  import w2s_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DOT  = 9'b000000010,
    ST_DOTW = 9'b000000100,
    ST_DIVX = 9'b000001000,
    ST_DIVY = 9'b000010000,
    ST_MAPX = 9'b000100000,
    ST_MAPY = 9'b001000000,
    ST_MAPW = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]   sw;
  logic [CFG_W-1:0]   sh;
  logic signed [31:0] vm [16];

  logic signed [31:0] px, py, pz;
  logic signed [31:0] cx, cy, cw;
  logic signed [31:0] sx, sy;
  logic signed [MA_W-1:0] nx, ny;
  logic               vis;
  logic [3:0]         cnt;
  logic [1:0]         rcnt;

  logic [1:0]         col;
  logic [1:0]         rsel;
  logic [HALF_W-1:0]  hw, hh;
  logic signed [31:0] sc_x, sc_y;
  logic signed [ACC_W-1:0] init_x, init_y;

  mac_ctl_t           mctl;
  logic signed [MA_W-1:0]  ma;
  logic signed [31:0]      mb;
  logic signed [ACC_W-1:0] minit;
  logic signed [ACC_W-1:0] mac_acc;
  logic               mac_res_valid;
  logic signed [31:0] mac_sat;

  div_req_t           dreq;
  logic signed [31:0] dsrc;
  logic [31:0]        dmag;
  logic               div_done;
  logic signed [QW-1:0] div_q;

  logic               accept;
  logic               w_ok;
  logic               out_load;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign accept   = in_valid & in_ready;
  assign w_ok     = (cw >= W_MIN);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // Rows 0, 1 and 3; row 2 is skipped.
  assign col  = cnt[1:0];
  assign rsel = (cnt[3:2] == 2'd2) ? 2'd3 : cnt[3:2];

  assign hw     = sw[CFG_W-1:1];
  assign hh     = sh[CFG_W-1:1];
  assign sc_x   = $signed({{(32-HALF_W){1'b0}}, hw}) + 32'sd1;
  assign sc_y   = 32'sd1 - $signed({{(32-HALF_W){1'b0}}, hh});
  assign init_x = $signed({{(ACC_W-HALF_W){1'b0}}, hw} << FRAC_BITS);
  assign init_y = $signed({{(ACC_W-HALF_W){1'b0}}, hh} << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= SW_RESET;
      sh <= SH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  sw <= cfg_data;
        REG_HEIGHT: sh <= cfg_data;
        default:    sw <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) vm[i] <= '0;
    end else if (accept && cmd == CMD_LOAD) begin
      vm[coef_index] <= coef_value;
    end
  end

  // MAC operand selection
  always_comb begin
    mctl  = '0;
    ma    = '0;
    mb    = '0;
    minit = '0;
    if (state == ST_DOT) begin
      mctl.issue = 1'b1;
      mctl.init  = (col == 2'd0);
      mctl.shift = 1'b1;
      mctl.last  = (col == 2'd3);
      mb         = vm[{rsel, col}];
      unique case (col)
        2'd0:    ma = sext_a(px);
        2'd1:    ma = sext_a(py);
        2'd2:    ma = sext_a(pz);
        default: ma = MAC_ONE;  // constant column
      endcase
    end else if (state == ST_MAPX) begin
      mctl  = '{issue: 1'b1, init: 1'b1, shift: 1'b0, last: 1'b1};
      ma    = nx;
      mb    = sc_x;
      minit = init_x;
    end else if (state == ST_MAPY) begin
      mctl  = '{issue: 1'b1, init: 1'b1, shift: 1'b0, last: 1'b1};
      ma    = ny;
      mb    = sc_y;
      minit = init_y;
    end
  end

  w2s_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .a         (ma),
    .b         (mb),
    .init_val  (minit),
    .acc       (mac_acc),
    .res_valid (mac_res_valid)
  );

  assign mac_sat = sat32(mac_acc);

  // Divider request: x first out of DOTW, y right after x finishes.
  assign dsrc           = (state == ST_DOTW) ? cx : cy;
  assign dmag           = dsrc[31] ? (~dsrc + 32'd1) : dsrc;
  assign dreq.start     = ((state == ST_DOTW) && (rcnt == 2'd3) && w_ok)
                       || ((state == ST_DIVX) && div_done);
  assign dreq.neg       = dsrc[31];
  assign dreq.dividend  = {dmag, {FRAC_BITS{1'b0}}};
  assign dreq.divisor   = cw[30:0];

  w2s_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (div_q)
  );

  // Result capture from the MAC
  always_ff @(posedge clk) begin
    if (mac_res_valid) begin
      if (state == ST_DOT || state == ST_DOTW) begin
        unique case (rcnt)
          2'd0:    cx <= mac_sat;
          2'd1:    cy <= mac_sat;
          default: cw <= mac_sat;
        endcase
      end else begin
        if (rcnt == 2'd0) sx <= mac_sat;
        else sy <= mac_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
    end
    if (state == ST_DIVX && div_done) nx <= clamp_ndc(div_q);
    if (state == ST_DIVY && div_done) ny <= clamp_ndc(div_q);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      rcnt  <= '0;
      vis   <= 1'b0;
    end else begin
      if (mac_res_valid) rcnt <= rcnt + 2'd1;
      unique case (state)
        ST_IDLE: begin
          if (accept && cmd == CMD_PROJ) begin
            cnt   <= '0;
            rcnt  <= '0;
            state <= ST_DOT;
          end
        end
        ST_DOT: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd11) state <= ST_DOTW;
        end
        ST_DOTW: begin
          if (rcnt == 2'd3) begin
            vis   <= w_ok;
            state <= w_ok ? ST_DIVX : ST_DONE;
          end
        end
        ST_DIVX: begin
          if (div_done) state <= ST_DIVY;
        end
        ST_DIVY: begin
          if (div_done) begin
            rcnt  <= '0;
            state <= ST_MAPX;
          end
        end
        ST_MAPX: state <= ST_MAPY;
        ST_MAPY: state <= ST_MAPW;
        ST_MAPW: begin
          if (rcnt == 2'd2) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      visible  <= vis;
      screen_x <= vis ? sx : 32'sd0;
      screen_y <= vis ? sy : 32'sd0;
    end
  end

`ifndef SYNTHESIS
  a_mac_in_work: assert property (@(posedge clk) disable iff (rst)
    mac_res_valid |-> (state != ST_IDLE && state != ST_DONE))
    else $error("MAC result outside of a point transaction");

  a_div_in_work: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVX || state == ST_DIVY))
    else $error("divider finished outside the divide states");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !visible) |-> (screen_x == 32'sd0 && screen_y == 32'sd0))
    else $error("hidden point with nonzero coordinates");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
